>>> rtl/core/tjs_pkg.sv
package tjs_pkg;

  // Width of the debounce threshold register.
  localparam int unsigned CfgWidth = 16;

  // Debounce threshold after reset, in ticks.
  localparam logic [CfgWidth-1:0] DebounceResetTicks = 16'd300;

  // Default width of the stable-sample counters.
  localparam int unsigned CountWidthDefault = 16;

  // Sequencer phases as they appear on the phase output.
  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_SELECTED    = 3'd1,
    PH_READY       = 3'd2,
    PH_SAFEZ_BEGIN = 3'd3,
    PH_RUNNING     = 3'd4,
    PH_SAFEZ_END   = 3'd5
  } phase_e;

  // One tick of button levels and machine status.
  typedef struct packed {
    logic table_button_raw;
    logic vacuum_button_raw;
    logic vacuum_confirmed;
    logic job_running;
    logic z_move_done;
    logic machine_claimed;
    logic own_job_pending;
  } in_item_t;

  // Output levels, command pulses and phase after one tick.
  typedef struct packed {
    logic       positioning_on;
    logic       vacuum_on;
    logic       claim_machine;
    logic       release_machine;
    logic       move_z_safe;
    logic       start_program;
    logic [2:0] phase;
  } out_item_t;

  // Debounced press events handed to the sequencer.
  typedef struct packed {
    logic table_rose;
    logic vacuum_rose;
  } events_t;

  // Settled level of a button: 0, 1, or not yet known.
  typedef logic [1:0] settled_t;
  localparam settled_t LevelUnknown = 2'd2;

endpackage

>>> rtl/core/tjs_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface tjs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/tjs_debounce.sv
module tjs_debounce
  import tjs_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   sample_i,
  input  logic [COUNT_WIDTH-1:0] thr_i,
  output logic                   rose_o
);

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   prev_q, prev_d;
  settled_t               settled_q, settled_d;
  logic                   same;
  logic                   settle_hit;

  // A new level settles when the run of equal samples reaches the threshold.
  assign same       = (sample_i == prev_q);
  assign settle_hit = same && (count_q == (thr_i - COUNT_WIDTH'(1)))
                      && ({1'b0, sample_i} != settled_q);
  assign rose_o     = settle_hit && sample_i;

  // Counter saturates at the threshold and restarts on a level change.
  always_comb begin
    count_d   = count_q;
    prev_d    = prev_q;
    settled_d = settled_q;
    if (step_i) begin
      prev_d = sample_i;
      if (same) begin
        if (settle_hit) begin
          settled_d = {1'b0, sample_i};
        end
        if (count_q < thr_i) begin
          count_d = count_q + COUNT_WIDTH'(1);
        end
      end else begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      prev_q    <= 1'b0;
      settled_q <= LevelUnknown;
    end else begin
      count_q   <= count_d;
      prev_q    <= prev_d;
      settled_q <= settled_d;
    end
  end

endmodule

>>> rtl/core/tjs_phase_fsm.sv
module tjs_phase_fsm
  import tjs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  events_t   ev_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  phase_e phase_q, phase_d;
  logic   pos_q, pos_d;
  logic   vac_q, vac_d;

  // Next phase and output levels.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    vac_d   = vac_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (ev_i.table_rose) begin
          pos_d   = 1'b1;
          phase_d = PH_SELECTED;
        end
      end
      PH_SELECTED: begin
        if (ev_i.vacuum_rose) begin
          vac_d = ~vac_q;
        end
        if (item_i.table_button_raw && item_i.vacuum_confirmed) begin
          pos_d   = 1'b0;
          phase_d = PH_READY;
        end
      end
      PH_READY: begin
        if (!item_i.job_running && !item_i.machine_claimed) begin
          phase_d = PH_SAFEZ_BEGIN;
        end
      end
      PH_SAFEZ_BEGIN: begin
        if (item_i.z_move_done) begin
          phase_d = PH_RUNNING;
        end
      end
      PH_RUNNING: begin
        if (!item_i.job_running && !item_i.own_job_pending) begin
          phase_d = PH_SAFEZ_END;
        end
      end
      PH_SAFEZ_END: begin
        if (item_i.z_move_done) begin
          vac_d   = 1'b0;
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Command pulses and the result beat, taken from the post-tick state.
  always_comb begin
    result_o                 = '0;
    result_o.positioning_on  = pos_d;
    result_o.vacuum_on       = vac_d;
    result_o.phase           = phase_d;
    unique case (phase_q)
      PH_READY: begin
        if (!item_i.job_running && !item_i.machine_claimed) begin
          result_o.claim_machine = 1'b1;
          result_o.move_z_safe   = 1'b1;
        end
      end
      PH_SAFEZ_BEGIN: begin
        result_o.start_program = item_i.z_move_done;
      end
      PH_RUNNING: begin
        result_o.move_z_safe = !item_i.job_running && !item_i.own_job_pending;
      end
      PH_SAFEZ_END: begin
        result_o.release_machine = item_i.z_move_done;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= 1'b0;
      vac_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      vac_q   <= vac_d;
    end
  end

endmodule

>>> rtl/core/table_job_sequencer.sv
// Job sequencer for one machining table. Each input beat is one tick of raw
// button levels and machine status; each tick yields exactly one result beat
// with the output levels, the command pulses and the phase after that tick.
// A beat is registered on entry and its result is loaded into the result
// register when that register is free. A new tick is taken every cycle while
// the output is not stalled; the input register can still take one more beat
// while a finished result waits at the output. Both buttons are debounced by
// COUNT_WIDTH-bit stable-sample counters against the debounce_ticks threshold
// (0 acts as 1, values above the counter range are clipped). Write the
// threshold only while no ticks are in flight.
module table_job_sequencer
  import tjs_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tjs_stream_if.sink   item_i,
  tjs_stream_if.source result_o,
  tjs_stream_if.sink   cfg_i
);

  localparam int unsigned ThrWidth = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;

  logic [CfgWidth-1:0]    debounce_ticks_q;
  logic [ThrWidth-1:0]    cfg_ext;
  logic [ThrWidth-1:0]    max_ext;
  logic [ThrWidth-1:0]    thr_ext;
  logic [COUNT_WIDTH-1:0] thr;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      advance;
  events_t   ev;
  out_item_t result;

  // Threshold register; the port always accepts a write.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= DebounceResetTicks;
    end else if (cfg_i.valid) begin
      debounce_ticks_q <= cfg_i.data;
    end
  end

  // Effective threshold: zero acts as one, clipped to the counter range.
  assign cfg_ext = ThrWidth'(debounce_ticks_q);
  assign max_ext = ThrWidth'({COUNT_WIDTH{1'b1}});
  always_comb begin
    if (debounce_ticks_q == '0) begin
      thr_ext = ThrWidth'(1);
    end else if (cfg_ext > max_ext) begin
      thr_ext = max_ext;
    end else begin
      thr_ext = cfg_ext;
    end
  end
  assign thr = thr_ext[COUNT_WIDTH-1:0];

  // A tick moves from the input register to the result register when free.
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_item_q <= item_i.data;
    end
  end

  // Button debouncers.
  tjs_debounce #(.COUNT_WIDTH(COUNT_WIDTH)) u_table_db (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (in_item_q.table_button_raw),
    .thr_i    (thr),
    .rose_o   (ev.table_rose)
  );

  tjs_debounce #(.COUNT_WIDTH(COUNT_WIDTH)) u_vacuum_db (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (in_item_q.vacuum_button_raw),
    .thr_i    (thr),
    .rose_o   (ev.vacuum_rose)
  );

  // Phase sequencer.
  tjs_phase_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .ev_i     (ev),
    .item_i   (in_item_q),
    .result_o (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= advance || (out_valid_q && !result_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_item_q;

endmodule

>>> rtl/core/tjs_checker.sv
module tjs_checker
  import tjs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  // Claiming the machine always comes with a safe Z move and enters safe-z begin.
  a_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.claim_machine |->
      out_data_i.move_z_safe && out_data_i.phase == PH_SAFEZ_BEGIN)
    else $error("claim without safe Z move in safe-z begin");

  // Program start lands in the running phase.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.start_program |-> out_data_i.phase == PH_RUNNING)
    else $error("program start outside running phase");

  // Release drops the vacuum and returns to idle.
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.release_machine |->
      !out_data_i.vacuum_on && out_data_i.phase == PH_IDLE)
    else $error("release without idle and vacuum off");

  // A safe Z move only enters one of the two safe-z phases.
  a_movez: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.move_z_safe |->
      out_data_i.phase == PH_SAFEZ_BEGIN || out_data_i.phase == PH_SAFEZ_END)
    else $error("safe Z move outside a safe-z phase");

endmodule

bind table_job_sequencer tjs_checker u_tjs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);

>>> test/table_job_sequencer_tb.sv
`timescale 1ns / 100ps

module table_job_sequencer_tb;
  import tjs_pkg::*;

  typedef logic [CfgWidth-1:0] cfg_word_t;

  // Debounce outcome of one tick for one button.
  typedef enum logic [1:0] {
    PRESS_NONE,
    PRESS_ROSE,
    PRESS_FELL
  } press_e;

  localparam int unsigned TableBtn  = 0;
  localparam int unsigned VacuumBtn = 1;
  localparam int unsigned CountMax  = (2 ** CountWidthDefault) - 1;
  localparam int unsigned InBits    = $bits(in_item_t);

  logic clk = 1'b0;
  logic rst_n;

  tjs_stream_if #(.T(in_item_t))  tick_if ();
  tjs_stream_if #(.T(out_item_t)) result_if ();
  tjs_stream_if #(.T(cfg_word_t)) cfg_if ();

  table_job_sequencer DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (tick_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  // Ticks waiting to be driven and outputs owed by the block, oldest first.
  in_item_t  tick_q[$];
  out_item_t outputs_due_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_cnt;

  // Shadow of the sequencer and the two debouncers.
  cfg_word_t                     debounce_reg;
  phase_e                        seq_phase;
  logic                          pos_lvl;
  logic                          vac_lvl;
  logic [CountWidthDefault-1:0]  stable_cnt[2];
  logic                          prev_smp[2];
  settled_t                      settled_lvl[2];

  always #4 clk = ~clk;

  task automatic note_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, logic [2:0] got, logic [2:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // One stable-sample counter step; reports a new settled level.
  function automatic press_e settle_button(int unsigned b, logic sample);
    int unsigned thr;
    press_e      ev;
    ev  = PRESS_NONE;
    thr = 32'(debounce_reg);
    if (thr == 0) thr = 1;
    if (thr > CountMax) thr = CountMax;
    if (sample == prev_smp[b]) begin
      if (stable_cnt[b] == thr - 1 && settled_t'(sample) != settled_lvl[b]) begin
        settled_lvl[b] = settled_t'(sample);
        ev = sample ? PRESS_ROSE : PRESS_FELL;
      end
      if (stable_cnt[b] < thr) stable_cnt[b] = stable_cnt[b] + 1'b1;
    end else begin
      stable_cnt[b] = '0;
    end
    prev_smp[b] = sample;
    return ev;
  endfunction

  // Advance the shadow sequencer by one tick and queue the output it owes.
  task automatic predict_tick(in_item_t t);
    press_e    tbl_ev;
    press_e    vac_ev;
    out_item_t o;
    o      = '0;
    tbl_ev = settle_button(TableBtn, t.table_button_raw);
    vac_ev = settle_button(VacuumBtn, t.vacuum_button_raw);
    case (seq_phase)
      PH_IDLE: begin
        if (tbl_ev == PRESS_ROSE) begin
          pos_lvl   = 1'b1;
          seq_phase = PH_SELECTED;
        end
      end
      PH_SELECTED: begin
        if (vac_ev == PRESS_ROSE) vac_lvl = ~vac_lvl;
        if (t.table_button_raw && t.vacuum_confirmed) begin
          pos_lvl   = 1'b0;
          seq_phase = PH_READY;
        end
      end
      PH_READY: begin
        if (!t.job_running && !t.machine_claimed) begin
          o.claim_machine = 1'b1;
          o.move_z_safe   = 1'b1;
          seq_phase       = PH_SAFEZ_BEGIN;
        end
      end
      PH_SAFEZ_BEGIN: begin
        if (t.z_move_done) begin
          o.start_program = 1'b1;
          seq_phase       = PH_RUNNING;
        end
      end
      PH_RUNNING: begin
        if (!t.job_running && !t.own_job_pending) begin
          o.move_z_safe = 1'b1;
          seq_phase     = PH_SAFEZ_END;
        end
      end
      PH_SAFEZ_END: begin
        if (t.z_move_done) begin
          vac_lvl           = 1'b0;
          o.release_machine = 1'b1;
          seq_phase         = PH_IDLE;
        end
      end
      default: begin
        seq_phase = PH_IDLE;
      end
    endcase
    o.positioning_on = pos_lvl;
    o.vacuum_on      = vac_lvl;
    o.phase          = seq_phase;
    outputs_due_q.push_back(o);
  endtask

  // Tick driver: hold a beat until it is taken, then maybe idle.
  always @(posedge clk) begin
    logic taken;
    logic waiting;
    if (!rst_n) begin
      tick_if.valid <= 1'b0;
    end else begin
      taken   = tick_if.valid && tick_if.ready;
      waiting = tick_if.valid && !tick_if.ready;
      if (taken) begin
        predict_tick(tick_if.data);
        void'(tick_q.pop_front());
      end
      if (!waiting) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tick_if.valid <= 1'b1;
          tick_if.data  <= tick_q[0];
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted beat with the oldest owed output.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (outputs_due_q.size() == 0) begin
          note_mismatch("result beat with no tick outstanding");
        end else begin
          want = outputs_due_q.pop_front();
          got  = result_if.data;
          check_field("positioning_on", 3'(got.positioning_on), 3'(want.positioning_on));
          check_field("vacuum_on", 3'(got.vacuum_on), 3'(want.vacuum_on));
          check_field("claim_machine", 3'(got.claim_machine), 3'(want.claim_machine));
          check_field("release_machine", 3'(got.release_machine),
                      3'(want.release_machine));
          check_field("move_z_safe", 3'(got.move_z_safe), 3'(want.move_z_safe));
          check_field("start_program", 3'(got.start_program), 3'(want.start_program));
          check_field("phase", got.phase, want.phase);
        end
      end
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Queue n ticks with fixed button levels and vacuum-confirmed bit; the other status bits are random.
  task automatic add_hold(int unsigned n, logic tbl, logic vac, logic conf);
    in_item_t t;
    repeat (n) begin
      t                   = in_item_t'(InBits'($urandom));
      t.table_button_raw  = tbl;
      t.vacuum_button_raw = vac;
      t.vacuum_confirmed  = conf;
      tick_q.push_back(t);
    end
  endtask

  // Queue n ticks of pure noise.
  task automatic add_noise(int unsigned n);
    repeat (n) tick_q.push_back(in_item_t'(InBits'($urandom)));
  endtask

  // A well-formed job: table press, vacuum toggles, ready, then random status.
  task automatic add_job(int unsigned thr, int unsigned presses);
    int unsigned hold;
    hold = (thr == 0) ? 1 : thr;
    add_hold(hold + $urandom_range(1, 3), 1'b1, 1'b0, 1'b0);
    add_hold(hold + 2, 1'b0, 1'b0, 1'b0);
    repeat (presses) begin
      add_hold(hold + $urandom_range(1, 2), 1'b0, 1'b1, 1'b0);
      add_hold(hold + $urandom_range(1, 2), 1'b0, 1'b0, 1'b0);
    end
    add_hold(1, 1'b1, 1'($urandom_range(1)), 1'b1);
    add_noise($urandom_range(2, 8));
  endtask

  // Mostly well-formed jobs, with bursts of pure noise between them.
  task automatic add_jobs(int unsigned thr, int unsigned jobs);
    repeat (jobs) begin
      if ($urandom_range(4) == 0) begin
        add_noise($urandom_range(5, 20));
      end
      add_job(thr, $urandom_range(0, 3));
    end
  endtask

  // Wait until every queued tick has been taken and every output checked.
  task automatic drain();
    while (tick_q.size() != 0 || outputs_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(cfg_word_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    debounce_reg = v;
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int unsigned thr;
    rst_n          = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    mismatch_cnt   = 0;
    send_idle_pct  = 32;
    recv_idle_pct  = 84;

    debounce_reg    = DebounceResetTicks;
    seq_phase       = PH_IDLE;
    pos_lvl         = 1'b0;
    vac_lvl         = 1'b0;
    stable_cnt[0]   = '0;
    stable_cnt[1]   = '0;
    prev_smp[0]     = 1'b0;
    prev_smp[1]     = 1'b0;
    settled_lvl[0]  = LevelUnknown;
    settled_lvl[1]  = LevelUnknown;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Threshold out of reset: a short burst of noise settles nothing.
    add_noise(20);
    drain();

    // Threshold zero acts as one. Bit order: table, vacuum, confirmed, job,
    // z done, claimed, pending.
    write_threshold('0);
    tick_q.push_back(in_item_t'(7'b0000000));
    tick_q.push_back(in_item_t'(7'b0000000));
    tick_q.push_back(in_item_t'(7'b1111111));
    tick_q.push_back(in_item_t'(7'b1001010));
    tick_q.push_back(in_item_t'(7'b0100000));
    tick_q.push_back(in_item_t'(7'b0100000));
    tick_q.push_back(in_item_t'(7'b0000000));
    tick_q.push_back(in_item_t'(7'b0000000));
    tick_q.push_back(in_item_t'(7'b0100000));
    // Vacuum press and the ready condition land on the same tick.
    tick_q.push_back(in_item_t'(7'b1110000));
    tick_q.push_back(in_item_t'(7'b0001000));
    tick_q.push_back(in_item_t'(7'b0000010));
    tick_q.push_back(in_item_t'(7'b0000000));
    tick_q.push_back(in_item_t'(7'b0001001));
    tick_q.push_back(in_item_t'(7'b0000100));
    tick_q.push_back(in_item_t'(7'b0001000));
    tick_q.push_back(in_item_t'(7'b0000001));
    tick_q.push_back(in_item_t'(7'b0000000));
    tick_q.push_back(in_item_t'(7'b0000000));
    tick_q.push_back(in_item_t'(7'b0000100));
    tick_q.push_back(in_item_t'(7'b1111111));
    tick_q.push_back(in_item_t'(7'b1111111));
    tick_q.push_back(in_item_t'(7'b1010000));
    tick_q.push_back(in_item_t'(7'b0000000));
    tick_q.push_back(in_item_t'(7'b0000100));
    add_jobs(0, 6);
    drain();

    // Sender mostly idle, receiver mostly ready.
    send_idle_pct = 84;
    recv_idle_pct = 32;
    write_threshold(cfg_word_t'(1));
    add_jobs(1, 6);
    drain();
    write_threshold(cfg_word_t'(2));
    add_jobs(2, 7);
    drain();

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    thr = $urandom_range(3, 6);
    write_threshold(cfg_word_t'(thr));
    add_jobs(thr, 5);
    drain();

    // Largest threshold: noise at the counter limit settles nothing.
    write_threshold('1);
    add_noise(20);
    drain();

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && outputs_due_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog in case the handshake stalls forever.
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tjs_pkg.sv
rtl/core/tjs_stream_if.sv
rtl/core/tjs_debounce.sv
rtl/core/tjs_phase_fsm.sv
rtl/core/table_job_sequencer.sv
rtl/core/tjs_checker.sv
test/table_job_sequencer_tb.sv
